@@ src/trie_prefix_counter_core_macros.svh @@
// assertion macros shared by the trie prefix counter modules
`ifndef TRIE_PREFIX_COUNTER_CORE_MACROS_SVH
`define TRIE_PREFIX_COUNTER_CORE_MACROS_SVH

// same-cycle implication, checked on clk, off while arst_n is low
`define TPC_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on clk, off while arst_n is low
`define TPC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/tpc_pkg.sv @@
// shared constants, types and the symbol decoder of the trie prefix counter
package tpc_pkg;

	localparam int NODE_COUNT    = 4096;
	localparam int ALPHABET_SIZE = 62;
	localparam int COUNT_BITS    = 16;

	localparam int NODE_BITS   = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam int FREE_BITS   = $clog2(NODE_COUNT + 1);
	localparam int SYM_BITS    = $clog2(ALPHABET_SIZE);
	localparam int ROW_BITS    = ALPHABET_SIZE * NODE_BITS;
	localparam int CMD_BITS    = 2;
	localparam int CHAR_BITS   = 8;
	localparam int PCOUNT_BITS = 16;
	localparam int STATUS_BITS = 2;

	localparam logic [COUNT_BITS-1:0]  COUNT_MAX  = {COUNT_BITS{1'b1}};
	localparam logic [PCOUNT_BITS-1:0] PCOUNT_MAX = {PCOUNT_BITS{1'b1}};

	// command codes
	localparam logic [CMD_BITS-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_BITS-1:0] CMD_QUERY  = 2'd1;
	localparam logic [CMD_BITS-1:0] CMD_CLEAR  = 2'd2;
	localparam logic [CMD_BITS-1:0] CMD_NOP    = 2'd3;

	// status codes
	localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_BITS-1:0] ST_BAD_CHAR  = 2'd1;
	localparam logic [STATUS_BITS-1:0] ST_POOL_FULL = 2'd2;

	// alphabet layout
	localparam int UPPER_BASE = 26;
	localparam int DIGIT_BASE = 52;
	localparam logic [CHAR_BITS-1:0] CH_LOWER_A = 8'h61;
	localparam logic [CHAR_BITS-1:0] CH_LOWER_Z = 8'h7A;
	localparam logic [CHAR_BITS-1:0] CH_UPPER_A = 8'h41;
	localparam logic [CHAR_BITS-1:0] CH_UPPER_Z = 8'h5A;
	localparam logic [CHAR_BITS-1:0] CH_DIGIT_0 = 8'h30;
	localparam logic [CHAR_BITS-1:0] CH_DIGIT_9 = 8'h39;

	// one row of the child store: the child pointer of every symbol of a node
	typedef logic [ALPHABET_SIZE-1:0][NODE_BITS-1:0] row_t;

	typedef struct packed {
		logic                 ok;
		logic [SYM_BITS-1:0]  idx;
	} sym_t;

	// walk stage to count stage
	typedef struct packed {
		logic                   valid;
		logic                   last;
		logic                   inc;
		logic                   use_count;
		logic [STATUS_BITS-1:0] status;
		logic [NODE_BITS-1:0]   node;
	} tally_req_t;

	// clearing pass position
	typedef struct packed {
		logic                 active;
		logic [NODE_BITS-1:0] addr;
	} sweep_t;

	function automatic sym_t sym_decode(input logic [CHAR_BITS-1:0] ch);
		sym_t s;
		s.ok  = 1'b1;
		s.idx = '0;
		case (ch) inside
			[CH_LOWER_A:CH_LOWER_Z]: s.idx = SYM_BITS'(ch - CH_LOWER_A);
			[CH_UPPER_A:CH_UPPER_Z]: s.idx = SYM_BITS'(32'(ch - CH_UPPER_A) + UPPER_BASE);
			[CH_DIGIT_0:CH_DIGIT_9]: s.idx = SYM_BITS'(32'(ch - CH_DIGIT_0) + DIGIT_BASE);
			default:                 s.ok  = 1'b0;
		endcase
		return s;
	endfunction

	function automatic logic [PCOUNT_BITS-1:0] clip_count(input logic [COUNT_BITS-1:0] c);
		logic [PCOUNT_BITS-1:0] r;
		r = PCOUNT_BITS'(c);
		if (COUNT_BITS > PCOUNT_BITS && 33'(c) > 33'(PCOUNT_MAX)) begin
			r = PCOUNT_MAX;
		end
		return r;
	endfunction

endpackage

@@ src/tpc_if.sv @@
// request and result channel interfaces of the trie prefix counter
interface tpc_req_if;
	import tpc_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CMD_BITS-1:0]  command;
	logic [CHAR_BITS-1:0] symbol;
	logic                 last;

	modport source(output valid, command, symbol, last, input ready);
	modport sink(input valid, command, symbol, last, output ready);
endinterface

interface tpc_rsp_if;
	import tpc_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [PCOUNT_BITS-1:0] prefix_count;
	logic [STATUS_BITS-1:0] status;

	modport source(output valid, prefix_count, status, input ready);
	modport sink(input valid, prefix_count, status, output ready);
endinterface

@@ src/trie_prefix_counter_core.sv @@
// trie prefix counter top level: child row store, count store, walk and count stages
// an insert or query character is handled as a child row read, then select and write back
// a result shows on rsp from the result register after the walk and count stages of the last character of its word
// a new character is taken only after the walk step of the last one and only while the count stage is free
// reset and the clear command run a clearing pass that zeroes every node of both stores with req.ready low
// command 3 is accepted and does nothing
module trie_prefix_counter_core (
	input  logic      clk,
	input  logic      arst_n,
	tpc_req_if.sink   req,
	tpc_rsp_if.source rsp
);
	import tpc_pkg::*;

	// walk stage to count stage handoff
	tally_req_t tally_req;
	sweep_t     sweep;
	logic       tally_free;

	// child row store: one row per node, one child pointer per symbol
	logic                 row_we;
	logic [NODE_BITS-1:0] row_waddr;
	logic [ROW_BITS-1:0]  row_wdata;
	logic                 row_re;
	logic [NODE_BITS-1:0] row_raddr;
	logic [ROW_BITS-1:0]  row_rdata;

	// prefix count store: one saturating count per node
	logic                  cnt_we;
	logic [NODE_BITS-1:0]  cnt_waddr;
	logic [COUNT_BITS-1:0] cnt_wdata;
	logic                  cnt_re;
	logic [NODE_BITS-1:0]  cnt_raddr;
	logic [COUNT_BITS-1:0] cnt_rdata;

	tpc_ram #(
		.WIDTH (ROW_BITS),
		.DEPTH (NODE_COUNT)
	) u_row_ram (
		.clk   (clk),
		.we    (row_we),
		.waddr (row_waddr),
		.wdata (row_wdata),
		.re    (row_re),
		.raddr (row_raddr),
		.rdata (row_rdata)
	);

	tpc_ram #(
		.WIDTH (COUNT_BITS),
		.DEPTH (NODE_COUNT)
	) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.re    (cnt_re),
		.raddr (cnt_raddr),
		.rdata (cnt_rdata)
	);

	// walk: reads the current node's row on accept, picks the child, allocates
	// a missing child on insert, tracks the word's failure and status
	tpc_walk u_walk (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.tally_free (tally_free),
		.tally_req  (tally_req),
		.sweep      (sweep),
		.row_we     (row_we),
		.row_waddr  (row_waddr),
		.row_wdata  (row_wdata),
		.row_re     (row_re),
		.row_raddr  (row_raddr),
		.row_rdata  (row_rdata),
		.cnt_re     (cnt_re),
		.cnt_raddr  (cnt_raddr)
	);

	// count stage: bumps the entered node's count from its registered walk result,
	// never overlapping the next walk's count read, and fills the result register
	tpc_tally u_tally (
		.clk        (clk),
		.arst_n     (arst_n),
		.tally_req  (tally_req),
		.sweep      (sweep),
		.tally_free (tally_free),
		.cnt_we     (cnt_we),
		.cnt_waddr  (cnt_waddr),
		.cnt_wdata  (cnt_wdata),
		.cnt_rdata  (cnt_rdata),
		.rsp        (rsp)
	);
endmodule

@@ src/tpc_ram.sv @@
// generic single-write single-read ram with registered read data
module tpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_BITS-1:0] waddr,
	input  logic [WIDTH-1:0]     wdata,
	input  logic                 re,
	input  logic [ADDR_BITS-1:0] raddr,
	output logic [WIDTH-1:0]     rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

@@ src/tpc_walk.sv @@
// trie walk: child row read, node allocation, word state and clearing pass
module tpc_walk (
	input  logic                       clk,
	input  logic                       arst_n,
	tpc_req_if.sink                    req,
	input  logic                       tally_free,
	output tpc_pkg::tally_req_t        tally_req,
	output tpc_pkg::sweep_t            sweep,
	output logic                       row_we,
	output logic [tpc_pkg::NODE_BITS-1:0] row_waddr,
	output logic [tpc_pkg::ROW_BITS-1:0]  row_wdata,
	output logic                       row_re,
	output logic [tpc_pkg::NODE_BITS-1:0] row_raddr,
	input  logic [tpc_pkg::ROW_BITS-1:0]  row_rdata,
	output logic                       cnt_re,
	output logic [tpc_pkg::NODE_BITS-1:0] cnt_raddr
);
	import tpc_pkg::*;

	`include "trie_prefix_counter_core_macros.svh"

	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_WALK  = 2'd2;

	localparam logic [NODE_BITS-1:0] LAST_NODE = NODE_BITS'(NODE_COUNT - 1);
	localparam logic [FREE_BITS-1:0] POOL_END  = FREE_BITS'(NODE_COUNT);

	logic [1:0]             state_q;
	logic [NODE_BITS-1:0]   clr_addr_q;
	logic [FREE_BITS-1:0]   next_free_q;
	logic [NODE_BITS-1:0]   cur_q;
	logic                   failed_q;
	logic [STATUS_BITS-1:0] wstatus_q;

	logic [CMD_BITS-1:0]    cmd_s1;
	sym_t                   sym_s1;
	logic                   last_s1;

	logic                   acc;
	logic                   walking;
	row_t                   row_rd;
	row_t                   row_upd;
	logic [NODE_BITS-1:0]   child;
	logic                   missing;
	logic                   pool_full;
	logic                   is_query;
	logic                   is_insert;
	logic                   walk_ok;
	logic                   alloc;
	logic [NODE_BITS-1:0]   new_node;
	logic                   fail_n;
	logic [STATUS_BITS-1:0] stat_n;

	assign req.ready = (state_q == S_IDLE) && tally_free;
	assign acc       = req.valid && req.ready;
	assign walking   = (state_q == S_WALK);

	assign row_rd    = row_rdata;
	assign child     = row_rd[sym_s1.idx];
	assign missing   = (child == '0);
	assign pool_full = (next_free_q == POOL_END);
	assign is_query  = (cmd_s1 == CMD_QUERY);
	assign is_insert = (cmd_s1 == CMD_INSERT);

	assign alloc    = walking && !failed_q && sym_s1.ok && missing && is_insert && !pool_full;
	assign walk_ok  = walking && !failed_q && sym_s1.ok && (!missing || alloc);
	assign new_node = alloc ? next_free_q[NODE_BITS-1:0] : child;

	// first failure of the word decides its status
	always_comb begin
		fail_n = failed_q;
		stat_n = wstatus_q;
		if (!failed_q) begin
			if (!sym_s1.ok) begin
				fail_n = 1'b1;
				stat_n = ST_BAD_CHAR;
			end else if (missing && is_query) begin
				fail_n = 1'b1;
			end else if (missing && pool_full) begin
				fail_n = 1'b1;
				stat_n = ST_POOL_FULL;
			end
		end
	end

	// child row read on acceptance, write back with the new pointer or zero rows
	always_comb begin
		row_upd = row_rd;
		row_upd[sym_s1.idx] = new_node;
		if (state_q == S_CLEAR) begin
			row_we    = 1'b1;
			row_waddr = clr_addr_q;
			row_wdata = '0;
		end else begin
			row_we    = alloc;
			row_waddr = cur_q;
			row_wdata = row_upd;
		end
	end

	assign row_re    = acc && (req.command == CMD_INSERT || req.command == CMD_QUERY);
	assign row_raddr = cur_q;

	assign cnt_re    = walk_ok;
	assign cnt_raddr = new_node;

	assign sweep.active = (state_q == S_CLEAR);
	assign sweep.addr   = clr_addr_q;

	assign tally_req.valid     = walking;
	assign tally_req.last      = last_s1;
	assign tally_req.inc       = walk_ok && is_insert;
	assign tally_req.use_count = walk_ok && is_query;
	assign tally_req.status    = stat_n;
	assign tally_req.node      = new_node;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_addr_q  <= '0;
			next_free_q <= FREE_BITS'(1);
			cur_q       <= '0;
			failed_q    <= 1'b0;
			wstatus_q   <= ST_OK;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == LAST_NODE) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (acc) begin
						case (req.command)
							CMD_CLEAR: begin
								state_q     <= S_CLEAR;
								clr_addr_q  <= '0;
								next_free_q <= FREE_BITS'(1);
								cur_q       <= '0;
								failed_q    <= 1'b0;
								wstatus_q   <= ST_OK;
							end
							CMD_INSERT, CMD_QUERY: begin
								state_q <= S_WALK;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_WALK: begin
					state_q <= S_IDLE;
					if (alloc) begin
						next_free_q <= next_free_q + 1'b1;
					end
					if (last_s1) begin
						cur_q     <= '0;
						failed_q  <= 1'b0;
						wstatus_q <= ST_OK;
					end else begin
						if (walk_ok) begin
							cur_q <= new_node;
						end
						failed_q  <= fail_n;
						wstatus_q <= stat_n;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			cmd_s1  <= req.command;
			sym_s1  <= sym_decode(req.symbol);
			last_s1 <= req.last;
		end
	end

	`TPC_ASSERT(a_cur_allocated, 1'b1, FREE_BITS'(cur_q) < next_free_q,
		"current node lies beyond the allocated pool")
	`TPC_ASSERT(a_alloc_room, alloc, !pool_full && missing,
		"allocation without free node or over an existing child")
	`TPC_ASSERT_NEXT(a_walk_follows, acc && (req.command == CMD_INSERT || req.command == CMD_QUERY),
		state_q == S_WALK && !req.ready, "walk step does not follow an accepted character")
endmodule

@@ src/tpc_tally.sv @@
// count stage: saturating prefix count update and result register
module tpc_tally (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tpc_pkg::tally_req_t           tally_req,
	input  tpc_pkg::sweep_t               sweep,
	output logic                          tally_free,
	output logic                          cnt_we,
	output logic [tpc_pkg::NODE_BITS-1:0]  cnt_waddr,
	output logic [tpc_pkg::COUNT_BITS-1:0] cnt_wdata,
	input  logic [tpc_pkg::COUNT_BITS-1:0] cnt_rdata,
	tpc_rsp_if.source                     rsp
);
	import tpc_pkg::*;

	`include "trie_prefix_counter_core_macros.svh"

	logic                   valid_s2;
	logic                   last_s2;
	logic                   inc_s2;
	logic                   use_s2;
	logic [STATUS_BITS-1:0] status_s2;
	logic [NODE_BITS-1:0]   node_s2;

	logic                   out_valid_q;
	logic [PCOUNT_BITS-1:0] out_count_q;
	logic [STATUS_BITS-1:0] out_status_q;

	logic                   fire;
	logic [COUNT_BITS-1:0]  count_inc;

	// count read data stays on the ram output until the next walk reads again
	assign fire       = valid_s2 && (!last_s2 || !out_valid_q || rsp.ready);
	assign tally_free = !valid_s2 || fire;
	assign count_inc  = (cnt_rdata == COUNT_MAX) ? cnt_rdata : cnt_rdata + 1'b1;

	always_comb begin
		if (sweep.active) begin
			cnt_we    = 1'b1;
			cnt_waddr = sweep.addr;
			cnt_wdata = '0;
		end else begin
			cnt_we    = fire && inc_s2;
			cnt_waddr = node_s2;
			cnt_wdata = count_inc;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.prefix_count = out_count_q;
	assign rsp.status       = out_status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (tally_req.valid) begin
				valid_s2 <= 1'b1;
			end else if (fire) begin
				valid_s2 <= 1'b0;
			end
			if (fire && last_s2) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tally_req.valid) begin
			last_s2   <= tally_req.last;
			inc_s2    <= tally_req.inc;
			use_s2    <= tally_req.use_count;
			status_s2 <= tally_req.status;
			node_s2   <= tally_req.node;
		end
		if (fire && last_s2) begin
			out_count_q  <= use_s2 ? clip_count(cnt_rdata) : '0;
			out_status_q <= status_s2;
		end
	end

	`TPC_ASSERT(a_load_empty, tally_req.valid, !valid_s2,
		"walk result arrives while count stage is still busy")
	`TPC_ASSERT(a_fail_zero, out_valid_q, out_status_q == ST_OK || out_count_q == '0,
		"failed word reports a nonzero prefix count")
	`TPC_ASSERT(a_no_sweep_update, sweep.active, !valid_s2,
		"count stage holds a request during the clearing pass")
endmodule
